// ===== sv/dlr_pkg.sv =====
`default_nettype none

package dlr_pkg;

    // Coordinate width of every endpoint and pixel field.
    localparam int COORD_BITS = 6;
    // Fraction bits of the slope and of the minor-axis accumulator.
    localparam int FRAC_BITS  = 16;

    // Dividend of the slope division, and the quotient that replaces it.
    localparam int DIV_W = COORD_BITS + FRAC_BITS;
    // Step counter of the division.
    localparam int CNT_W = $clog2(DIV_W + 1);
    // Biased accumulator: two guard bits above the coordinate bits.
    localparam int ACC_W = COORD_BITS + 2 + FRAC_BITS;

    // Stream payload widths, rounded up to whole bytes.
    localparam int S_TDATA_W = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((2 * COORD_BITS + 7) / 8) * 8;

endpackage : dlr_pkg

`default_nettype wire

// ===== sv/dda_line_raster.sv =====
`default_nettype none

// DDA line rasterizer. Each request on the slave stream carries two endpoints;
// the block answers with one master-stream request per pixel of the segment,
// walking the major axis upward from the endpoint lower on that axis, and
// marks the final pixel with m_axis_tlast. The line is shallow when |dx| > |dy|
// and steep otherwise (an exact diagonal is steep); a vertical line and a
// single point are walked along y without any division. For other lines the
// slope is found once by a restoring divider that retires one quotient bit per
// cycle and is then added into a fixed-point accumulator with FRAC_BITS
// fraction bits, one pixel per cycle while the master side keeps m_axis_tready
// high, each pixel rounded half up. The block takes the request, runs the
// division (skipped for vertical lines), then walks the pixels, 1 to 64 of
// them; a line that is not vertical has at least 2 pixels. s_axis_tready is
// high only while the block is idle; the last pixel may still wait in the
// output register when the next line is taken.
module dda_line_raster (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // tdata fields from bit 0 up: x_start, y_start, x_end, y_end, zero fill.
    input  wire logic [dlr_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata fields from bit 0 up: pixel_x, pixel_y, zero fill.
    output logic [dlr_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    output logic                                m_axis_tlast,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready
);
    import dlr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_WALK
    } state_t;

    localparam logic [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (FRAC_BITS - 1);

    state_t                  state_reg;
    logic [DIV_W-1:0]        div_reg;      // dividend, shifted out as quotient bits enter
    logic [COORD_BITS-1:0]   rem_reg;
    logic [COORD_BITS-1:0]   den_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [ACC_W-1:0]        acc_reg;      // minor axis, biased by 2^COORD_BITS plus one half
    logic [COORD_BITS-1:0]   major_reg;
    logic [COORD_BITS-1:0]   hi_reg;
    logic                    neg_reg;
    logic                    shallow_reg;
    logic                    m_valid_reg;
    logic                    m_last_reg;
    logic [COORD_BITS-1:0]   px_reg;
    logic [COORD_BITS-1:0]   py_reg;

    // Endpoint decode of the incoming request.
    logic [COORD_BITS-1:0] xa, ya, xb, yb;
    logic [COORD_BITS-1:0] adx, ady, an, ad;
    logic [COORD_BITS-1:0] lo, hi, start;
    logic                  x_dec, y_dec, shallow, vertical;

    always_comb begin
        xa = s_axis_tdata[0 +: COORD_BITS];
        ya = s_axis_tdata[COORD_BITS +: COORD_BITS];
        xb = s_axis_tdata[2 * COORD_BITS +: COORD_BITS];
        yb = s_axis_tdata[3 * COORD_BITS +: COORD_BITS];
        x_dec    = xb < xa;
        y_dec    = yb < ya;
        adx      = x_dec ? (xa - xb) : (xb - xa);
        ady      = y_dec ? (ya - yb) : (yb - ya);
        vertical = (xa == xb);
        shallow  = adx > ady;
        if (shallow) begin
            an    = ady;
            ad    = adx;
            lo    = x_dec ? xb : xa;
            hi    = x_dec ? xa : xb;
            start = x_dec ? yb : ya;
        end else begin
            an    = adx;
            ad    = ady;
            lo    = y_dec ? yb : ya;
            hi    = y_dec ? ya : yb;
            start = y_dec ? xb : xa;
        end
    end

    // One restoring division step.
    logic [COORD_BITS:0]   div_shift;
    logic [COORD_BITS:0]   div_diff;
    logic                  div_ge;
    logic [COORD_BITS-1:0] rem_next;
    logic [DIV_W-1:0]      div_next;

    always_comb begin
        div_shift = {rem_reg, div_reg[DIV_W-1]};
        div_diff  = div_shift - {1'b0, den_reg};
        div_ge    = div_shift >= {1'b0, den_reg};
        rem_next  = div_ge ? div_diff[COORD_BITS-1:0] : div_shift[COORD_BITS-1:0];
        div_next  = {div_reg[DIV_W-2:0], div_ge};
    end

    // Accumulator update; in the walk div_reg holds the slope magnitude.
    logic [ACC_W-1:0] inc_mag;
    logic [ACC_W-1:0] acc_next;
    logic             out_free;
    logic             pix_last;

    always_comb begin
        inc_mag  = {{(ACC_W - DIV_W){1'b0}}, div_reg};
        acc_next = neg_reg ? (acc_reg - inc_mag) : (acc_reg + inc_mag);
        out_free = !m_valid_reg || m_axis_tready;
        pix_last = (major_reg == hi_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            // Outside the walk a taken pixel simply leaves the output register.
            if (m_axis_tready && (state_reg != ST_WALK)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        major_reg   <= lo;
                        hi_reg      <= hi;
                        shallow_reg <= shallow;
                        neg_reg     <= x_dec ^ y_dec;
                        den_reg     <= ad;
                        rem_reg     <= '0;
                        cnt_reg     <= '0;
                        acc_reg     <= ACC_W'({2'b01, start, {FRAC_BITS{1'b0}}}) | ACC_HALF;
                        if (vertical) begin
                            div_reg   <= '0;
                            state_reg <= ST_WALK;
                        end else begin
                            div_reg   <= {an, {FRAC_BITS{1'b0}}} + DIV_W'(ad >> 1);
                            state_reg <= ST_DIVIDE;
                        end
                    end
                end
                ST_DIVIDE: begin
                    div_reg <= div_next;
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(DIV_W - 1)) begin
                        state_reg <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_last_reg  <= pix_last;
                        if (shallow_reg) begin
                            px_reg <= major_reg;
                            py_reg <= acc_reg[FRAC_BITS +: COORD_BITS];
                        end else begin
                            px_reg <= acc_reg[FRAC_BITS +: COORD_BITS];
                            py_reg <= major_reg;
                        end
                        if (pix_last) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            major_reg <= major_reg + COORD_BITS'(1);
                            acc_reg   <= acc_next;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = M_TDATA_W'({py_reg, px_reg});

    // The divider remainder always stays below the divisor.
    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIVIDE |-> rem_reg < den_reg)
        else $error("divider remainder reached the divisor");

    // The slope magnitude never exceeds one whole step.
    a_slope_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WALK |-> div_reg <= (DIV_W'(1) << FRAC_BITS))
        else $error("slope magnitude above one");

    // The major-axis counter never runs past the far endpoint.
    a_major_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WALK |-> major_reg <= hi_reg)
        else $error("major axis ran past the end of the line");

    // A pixel is only loaded into a free output slot, so none is overwritten.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_axis_tready) |=> m_valid_reg && $stable(px_reg)
            && $stable(py_reg) && $stable(m_last_reg))
        else $error("pending pixel was overwritten");

endmodule : dda_line_raster

`default_nettype wire
